FILE: rtl/wavetable_envelope_mixer_core_macros.svh
// assertion macros for the wavetable envelope mixer checker
// expects i_clk and i_rst_n in the scope of use
`ifndef WAVETABLE_ENVELOPE_MIXER_CORE_MACROS_SVH
`define WAVETABLE_ENVELOPE_MIXER_CORE_MACROS_SVH

// same-cycle implication
`define WEM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/wem_pkg.sv
// shared types and constants of the wavetable envelope mixer
// no dependencies
package wem_pkg;

    localparam int VOICES_DEF    = 4;
    localparam int ENV_STEPS_DEF = 128;

    localparam int OP_W        = 3;
    localparam int VOICE_W     = 2;
    localparam int TADDR_W     = 7;
    localparam int VALUE_W     = 16;
    localparam int LEVEL_W     = 8;
    localparam int SAMPLE_W    = 8;
    localparam int ACC16_W     = 16;
    localparam int WAVE_AW     = 6;
    localparam int WAVE_ENTRIES = 64;
    localparam int ENV_IDX_W   = 8;
    localparam int WAVE_SHIFT  = 10;

    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_WAVE  = 3'd1;
    localparam logic [OP_W-1:0] OP_ENV   = 3'd2;
    localparam logic [OP_W-1:0] OP_START = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

    typedef struct packed {
        logic [ACC16_W-1:0] phase;
        logic [ACC16_W-1:0] incr;
        logic [ACC16_W-1:0] envc;
    } t_voice;

    typedef struct packed {
        logic               wave_we;
        logic               env_we;
        logic [TADDR_W-1:0] addr;
        logic [SAMPLE_W-1:0] data;
    } t_tbl_wr;

    typedef struct packed {
        logic                 rd_en;
        logic [WAVE_AW-1:0]   wave_addr;
        logic [ENV_IDX_W-1:0] env_idx;
    } t_tbl_rd;

endpackage

FILE: rtl/wem_tables.sv
// wave and envelope table memories, one write and one registered read each
// depends on wem_pkg
module wem_tables #(
    parameter int ENVELOPE_STEPS = wem_pkg::ENV_STEPS_DEF
) (
    input  logic                          i_clk,
    input  wem_pkg::t_tbl_wr              i_wr,
    input  wem_pkg::t_tbl_rd              i_rd,
    output logic [wem_pkg::SAMPLE_W-1:0]  o_wave,
    output logic [wem_pkg::SAMPLE_W-1:0]  o_env
);
    import wem_pkg::*;

    localparam int EW = $clog2(ENVELOPE_STEPS);

    logic [SAMPLE_W-1:0] r_wave_mem [WAVE_ENTRIES];
    logic [SAMPLE_W-1:0] r_env_mem  [ENVELOPE_STEPS];
    logic [SAMPLE_W-1:0] r_wave_q;
    logic [SAMPLE_W-1:0] r_env_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.wave_we) begin
            r_wave_mem[i_wr.addr[WAVE_AW-1:0]] <= i_wr.data;
        end
        if (i_wr.env_we) begin
            r_env_mem[EW'(i_wr.addr)] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.rd_en) begin
            r_wave_q <= r_wave_mem[i_rd.wave_addr];
            r_env_q  <= r_env_mem[i_rd.env_idx[EW-1:0]];
        end
    end

    assign o_wave = r_wave_q;
    assign o_env  = r_env_q;

endmodule

FILE: rtl/wavetable_envelope_mixer_core.sv
// sample tick: the input is stalled while the voices are processed and until the result
// is loaded into the output register, which waits while a held result is stalled
// table writes and start note do not stall the input; clear phase stalls it in ST_CLR
// synchronous active-low reset clears control, output valid and voice state valid bits;
// table memories hold no reset value
// voice state memory, pipeline and mixer; depends on wem_pkg and wem_tables
module wavetable_envelope_mixer_core #(
    parameter int VOICES         = wem_pkg::VOICES_DEF,
    parameter int ENVELOPE_STEPS = wem_pkg::ENV_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [wem_pkg::OP_W-1:0]      i_operation,
    input  logic [wem_pkg::VOICE_W-1:0]   i_voice,
    input  logic [wem_pkg::TADDR_W-1:0]   i_table_address,
    input  logic [wem_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [wem_pkg::LEVEL_W-1:0]   o_first_level,
    output logic [wem_pkg::LEVEL_W-1:0]   o_second_level
);
    import wem_pkg::*;

    localparam int VW      = $clog2(VOICES);
    localparam int ACC_MAX = (VOICES - VOICES / 2) * 255;
    localparam int AW      = $clog2(ACC_MAX + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TICK = 2'd1;
    localparam logic [1:0] ST_CLR  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [VW:0]   r_cnt, n_cnt;

    t_voice        r_voice_mem [VOICES];
    logic          r_voice_vld [VOICES];
    t_voice        r_rd_data;
    logic          r_rd_ent;

    logic          r_s1_vld;
    logic          r_s1_clr;
    logic [VW-1:0] r_s1_idx;
    logic          r_s2_vld;
    logic          r_s2_upper;

    logic [AW-1:0] r_acc_lo, r_acc_hi;
    logic          r_out_vld;
    logic [LEVEL_W-1:0] r_first, r_second;

    logic          in_acc, voice_ok, load_out;
    logic          rd_en;
    logic [VW-1:0] rd_addr;
    t_voice        rd_voice;
    logic [ACC16_W-1:0]   s1_phase;
    logic [ENV_IDX_W-1:0] s1_idx;
    logic          s1_act;
    logic          we;
    logic [VW-1:0] waddr;
    t_voice        wdata;
    t_tbl_wr       tbl_wr;
    t_tbl_rd       tbl_rd;
    logic [SAMPLE_W-1:0] wave_q, env_q;
    logic [2*SAMPLE_W-1:0] prod;
    logic [AW-2:0] half_lo, half_hi;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign voice_ok   = int'(i_voice) < VOICES;

    // voice state read port
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (r_state == ST_TICK && int'(r_cnt) < VOICES) begin
            rd_en   = 1'b1;
            rd_addr = r_cnt[VW-1:0];
        end else if (in_acc && i_operation == OP_CLEAR && voice_ok) begin
            rd_en   = 1'b1;
            rd_addr = VW'(i_voice);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_voice_mem[rd_addr];
            r_rd_ent  <= r_voice_vld[rd_addr];
        end
    end

    assign rd_voice = r_rd_ent ? r_rd_data : '0;

    // stage 1: advance phase and envelope
    assign s1_phase = rd_voice.phase + rd_voice.incr;
    assign s1_idx   = rd_voice.envc[ACC16_W-1:ACC16_W-ENV_IDX_W];
    assign s1_act   = ~r_s1_clr && (int'(s1_idx) < ENVELOPE_STEPS);

    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (r_s1_vld) begin
            we         = 1'b1;
            waddr      = r_s1_idx;
            wdata.incr = rd_voice.incr;
            if (r_s1_clr) begin
                wdata.phase = '0;
                wdata.envc  = rd_voice.envc;
            end else begin
                wdata.phase = s1_phase;
                wdata.envc  = s1_act ? rd_voice.envc + 16'd1 : rd_voice.envc;
            end
        end else if (in_acc && i_operation == OP_START && voice_ok) begin
            we         = 1'b1;
            waddr      = VW'(i_voice);
            wdata.incr = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_voice_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VOICES; i++) begin
                r_voice_vld[i] <= 1'b0;
            end
        end else if (we) begin
            r_voice_vld[waddr] <= 1'b1;
        end
    end

    // table memories
    always_comb begin
        tbl_wr.wave_we = in_acc && i_operation == OP_WAVE &&
                         int'(i_table_address) < WAVE_ENTRIES;
        tbl_wr.env_we  = in_acc && i_operation == OP_ENV &&
                         int'(i_table_address) < ENVELOPE_STEPS;
        tbl_wr.addr    = i_table_address;
        tbl_wr.data    = i_value[SAMPLE_W-1:0];
        tbl_rd.rd_en     = r_s1_vld && s1_act;
        tbl_rd.wave_addr = s1_phase[ACC16_W-1:WAVE_SHIFT];
        tbl_rd.env_idx   = s1_idx;
    end

    wem_tables #(
        .ENVELOPE_STEPS(ENVELOPE_STEPS)
    ) u_tables (
        .i_clk  (i_clk),
        .i_wr   (tbl_wr),
        .i_rd   (tbl_rd),
        .o_wave (wave_q),
        .o_env  (env_q)
    );

    // stage 2: scale and mix
    assign prod = wave_q * env_q;

    always_ff @(posedge i_clk) begin
        r_s1_clr   <= (r_state == ST_IDLE);
        r_s1_idx   <= rd_addr;
        r_s2_upper <= int'(r_s1_idx) >= VOICES / 2;
        if (in_acc && i_operation == OP_TICK) begin
            r_acc_lo <= '0;
            r_acc_hi <= '0;
        end else if (r_s2_vld) begin
            if (r_s2_upper) begin
                r_acc_hi <= r_acc_hi + AW'(prod[2*SAMPLE_W-1:SAMPLE_W]);
            end else begin
                r_acc_lo <= r_acc_lo + AW'(prod[2*SAMPLE_W-1:SAMPLE_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= rd_en;
            r_s2_vld <= r_s1_vld && s1_act;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (in_acc && i_operation == OP_TICK) begin
                    n_state = ST_TICK;
                end else if (in_acc && i_operation == OP_CLEAR && voice_ok) begin
                    n_state = ST_CLR;
                end
            end
            ST_TICK: begin
                if (int'(r_cnt) < VOICES) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (!r_s1_vld && !r_s2_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_CLR: begin
                n_state = ST_IDLE;
            end
            ST_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // output register
    assign load_out = (r_state == ST_DONE) && (!r_out_vld || !i_out_stall);
    assign half_lo  = r_acc_lo[AW-1:1];
    assign half_hi  = r_acc_hi[AW-1:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_first  <= (int'(half_lo) > 255) ? '1 : LEVEL_W'(half_lo);
            r_second <= (int'(half_hi) > 255) ? '1 : LEVEL_W'(half_hi);
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_first_level  = r_first;
    assign o_second_level = r_second;

endmodule

FILE: rtl/wem_checker.sv
// port-level checks of the wavetable envelope mixer, bound to the top level
// depends on wem_pkg and wavetable_envelope_mixer_core_macros.svh
`include "wavetable_envelope_mixer_core_macros.svh"

module wem_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic [wem_pkg::OP_W-1:0]      i_operation,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [wem_pkg::LEVEL_W-1:0]   o_first_level,
    input logic [wem_pkg::LEVEL_W-1:0]   o_second_level
);
    import wem_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    `WEM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")
    `WEM_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_first_level) && $stable(o_second_level), "stalled result changed")
    `WEM_ASSERT_NEXT(a_tick_busy, in_acc && i_operation == OP_TICK, o_in_stall, "tick transaction did not occupy the block")
    `WEM_ASSERT_NEXT(a_no_early_result, in_acc && !o_out_valid, !o_out_valid, "result appeared one cycle after a transaction")

endmodule

bind wavetable_envelope_mixer_core wem_checker u_wem_checker (.*);
